/* hdl/abbs_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// abbs_pkg
// Shared types and constants for the ascending sorter cell chain.
// ----------------------------------------------------------------------------
package abbs_pkg;

  // Capacity of the cell chain (number of stored elements per set).
  localparam int unsigned MAX_ELEMENTS = 32;

  typedef logic signed [31:0] elem_t;

  // Per-cycle command broadcast to every cell.
  typedef struct packed {
    logic load;    // insert the broadcast element into the sorted chain
    logic unload;  // shift the whole chain one place toward cell 0
  } cell_ctrl_t;

endpackage
`default_nettype wire

/* hdl/ascending_bubble_sorter.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ascending_bubble_sorter
// Stable ascending sort of a marked set of signed 32-bit values.
// ----------------------------------------------------------------------------
// Elements enter one per cycle while no set is draining, into a chain of
// MAX_ELEMENTS cells that is always kept in ascending order: each new element
// is broadcast, every cell compares it with its own content, and the cells
// past the insertion point shift one place outward in the same cycle. The
// transaction carrying last_in ends the set; the chain then drains through
// cell 0, one result per cycle while out_stall is low, with last_out on the
// final result and overflow set on every result if any element of the set
// was dropped because the chain was full. The first result is offered in the
// cycle after the marked transaction. The input channel is stalled for the
// whole drain, since loading and unloading share the one chain.
// ----------------------------------------------------------------------------
module ascending_bubble_sorter (
  input  wire logic           clk,
  input  wire logic           rst,
  // input channel
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire abbs_pkg::elem_t value,
  input  wire logic           last_in,
  // output channel
  output logic                out_valid,
  input  wire logic           out_stall,
  output abbs_pkg::elem_t     sorted_value,
  output logic                last_out,
  output logic                overflow
);

  localparam int unsigned N = abbs_pkg::MAX_ELEMENTS;

  abbs_pkg::elem_t    elems [N];
  logic [N-1:0]       occs;
  logic [N-1:0]       inss;
  abbs_pkg::cell_ctrl_t ctrl;

  logic draining;   // set holds the sorted run being emitted
  logic dropped;    // an element of this set was discarded

  logic in_take;
  logic out_take;
  logic full;

  assign in_take  = in_valid && !in_stall;
  assign out_take = out_valid && !out_stall;
  assign full     = occs[N-1];

  // While draining, no new transaction is taken on the input side.
  assign in_stall = draining;

  assign ctrl.load   = in_take && !full;
  assign ctrl.unload = out_take;

  // Cell chain; cell 0 holds the smallest element.
  for (genvar i = 0; i < N; i++) begin : g_cell
    abbs_pkg::elem_t l_elem;
    abbs_pkg::elem_t r_elem;
    logic            l_occ;
    logic            l_ins;
    logic            r_occ;

    if (i == 0) begin : g_first
      assign l_elem = value;
      assign l_occ  = 1'b0;
      assign l_ins  = 1'b0;
    end else begin : g_mid
      assign l_elem = elems[i-1];
      assign l_occ  = occs[i-1];
      assign l_ins  = inss[i-1];
    end

    if (i == N - 1) begin : g_end
      assign r_elem = elems[i];
      assign r_occ  = 1'b0;
    end else begin : g_inner
      assign r_elem = elems[i+1];
      assign r_occ  = occs[i+1];
    end

    abbs_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .new_elem   (value),
      .left_elem  (l_elem),
      .left_occ   (l_occ),
      .left_ins   (l_ins),
      .right_elem (r_elem),
      .right_occ  (r_occ),
      .elem       (elems[i]),
      .occ        (occs[i]),
      .ins        (inss[i])
    );
  end

  // Set control: start draining on the marked transaction, finish after the
  // final result is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      draining <= 1'b0;
      dropped  <= 1'b0;
    end else begin
      if (in_take) begin
        if (full) begin
          dropped <= 1'b1;
        end
        if (last_in) begin
          draining <= 1'b1;
        end
      end
      if (out_take && last_out) begin
        draining <= 1'b0;
        dropped  <= 1'b0;
      end
    end
  end

  // Results come straight from cell 0 (a register).
  assign out_valid    = draining;
  assign sorted_value = elems[0];
  assign last_out     = !occs[1];
  assign overflow     = dropped;

endmodule
`default_nettype wire

/* hdl/abbs_cell.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// abbs_cell
// One slot of the insertion chain: holds an element, compares it with the
// broadcast element and trades data with its neighbors.
// ----------------------------------------------------------------------------
module abbs_cell (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire abbs_pkg::cell_ctrl_t ctrl,
  input  wire abbs_pkg::elem_t    new_elem,
  input  wire abbs_pkg::elem_t    left_elem,
  input  wire logic               left_occ,
  input  wire logic               left_ins,
  input  wire abbs_pkg::elem_t    right_elem,
  input  wire logic               right_occ,
  output abbs_pkg::elem_t         elem,
  output logic                    occ,
  output logic                    ins
);

  // Insertion point is at or before this cell. Strict compare keeps equal
  // values in arrival order; an empty cell acts as +infinity.
  assign ins = !occ || (new_elem < elem);

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= 1'b0;
    end else if (ctrl.unload) begin
      occ <= right_occ;
    end else if (ctrl.load) begin
      if (left_ins) begin
        occ <= left_occ;
      end else if (ins) begin
        occ <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.unload) begin
      elem <= right_elem;
    end else if (ctrl.load) begin
      if (left_ins) begin
        elem <= left_elem;
      end else if (ins) begin
        elem <= new_elem;
      end
    end
  end

endmodule
`default_nettype wire

/* hdl/abbs_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// abbs_checker
// Port-level checks for the ascending sorter, bound to the top level.
// ----------------------------------------------------------------------------
module abbs_checker (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           in_valid,
  input wire logic           in_stall,
  input wire abbs_pkg::elem_t value,
  input wire logic           last_in,
  input wire logic           out_valid,
  input wire logic           out_stall,
  input wire abbs_pkg::elem_t sorted_value,
  input wire logic           last_out,
  input wire logic           overflow
);

  logic            in_run;    // a result of the current run was taken
  abbs_pkg::elem_t prev_val;
  logic            prev_ovf;
  logic            out_take;

  assign out_take = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_run <= 1'b0;
    end else if (out_take) begin
      in_run <= !last_out;
    end
  end

  always_ff @(posedge clk) begin
    if (out_take) begin
      prev_val <= sorted_value;
      prev_ovf <= overflow;
    end
  end

  // A stalled input transaction holds until taken.
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(value) && $stable(last_in))
    else $error("input changed while stalled");

  // A pending result holds until taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(sorted_value))
    else $error("result changed while stalled");

  // No input transaction is taken while a run is being emitted.
  a_no_load_in_drain: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input accepted during drain");

  // Results within a run never decrease.
  a_ascending: assert property (@(posedge clk) disable iff (rst)
    out_take && in_run |-> sorted_value >= prev_val)
    else $error("results out of order");

  // Overflow is one value for the whole run.
  a_ovf_steady: assert property (@(posedge clk) disable iff (rst)
    out_valid && in_run |-> overflow == prev_ovf)
    else $error("overflow changed within a run");

endmodule

bind ascending_bubble_sorter abbs_checker u_abbs_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .value        (value),
  .last_in      (last_in),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .sorted_value (sorted_value),
  .last_out     (last_out),
  .overflow     (overflow)
);
`default_nettype wire
